[sv/hbf_pkg.sv]
package hbf_pkg;

	localparam int MAX_BINS    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int TABLE_DEPTH = MAX_BINS + 1;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int NB_W        = 7;

	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic [NB_W-1:0]               nb_t;
	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic   we;
		idx_t   waddr;
		value_t wdata;
		idx_t   raddr;
	} ram_req_t;

	// zero counts as one bin, anything above the table saturates
	function automatic nb_t bins_in_use(nb_t n);
		nb_t r;
		if (n == '0)
			r = NB_W'(1);
		else if (n > NB_W'(MAX_BINS))
			r = NB_W'(MAX_BINS);
		else
			r = n;
		return r;
	endfunction

endpackage

[sv/hbf_item_if.sv]
interface hbf_item_if;
	import hbf_pkg::*;

	logic   valid;
	logic   ready;
	logic   op;
	logic [6:0] edge_index;
	value_t value;
	logic   last_sample;

	modport source (output valid, output op, output edge_index, output value,
		output last_sample, input ready);
	modport sink (input valid, input op, input edge_index, input value,
		input last_sample, output ready);
endinterface

[sv/hbf_result_if.sv]
interface hbf_result_if;
	import hbf_pkg::*;

	logic       valid;
	logic       ready;
	logic [6:0] bin;
	logic       no_bin;
	logic       batch_end;

	modport source (output valid, output bin, output no_bin, output batch_end,
		input ready);
	modport sink (input valid, input bin, input no_bin, input batch_end,
		output ready);
endinterface

[sv/histogram_bin_finder_core.sv]
// Histogram bin finder.
// items: valid/ready beats. op = load writes value into edge slot edge_index
// (slots above the table are dropped) and gives no result; op = classify
// looks the sample up in the edge table and gives one beat on results:
// bin, no_bin (sample in no bin, bin = bins in use) and batch_end.
// cfg_we/cfg_wdata set num_bins; write it only while the block is idle.
// Flow: a load is written into the table as it is accepted. A classify beat
// goes through RD_LO, RD_HI and CHK, then s halving steps (none when the
// sample is out of range, sits on the top edge or only one bin is in use,
// else up to ceil(log2(bins in use)), so at most 6), then DONE, which puts
// the result on results. Only one edge is read per step, through the single
// read port of the edge RAM; no new item is taken until DONE has finished.
// A finished result sits in the output register; the search carries on with
// the next item while results is stalled, and only waits before writing
// a second result into a full register.
// Reset clears the control state and sets num_bins to 1; the edge table is
// not cleared and must be loaded before use.
module histogram_bin_finder_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  hbf_pkg::nb_t cfg_wdata,
	hbf_item_if.sink     items,
	hbf_result_if.source results
);
	import hbf_pkg::*;

	nb_t      num_bins_q;
	ram_req_t ram_req;
	value_t   rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			num_bins_q <= NB_W'(1);
		else if (cfg_we)
			num_bins_q <= cfg_wdata;
	end

	hbf_edge_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	hbf_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_bins (num_bins_q),
		.items    (items),
		.results  (results),
		.ram_req  (ram_req),
		.rdata    (rdata)
	);

	// the table is only written from an accepted load beat
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (items.valid && items.ready && items.op == OP_LOAD))
		else $error("edge write without a load beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.bin <= 7'(MAX_BINS)))
		else $error("bin beyond table");

	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.no_bin) |-> (results.bin != '0))
		else $error("no_bin with bin zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.no_bin) |-> (results.bin < 7'(MAX_BINS)))
		else $error("in-range bin out of range");
endmodule

[sv/hbf_edge_ram.sv]
module hbf_edge_ram (
	input  logic              clk,
	input  hbf_pkg::ram_req_t req,
	output hbf_pkg::value_t   rdata
);
	import hbf_pkg::*;

	value_t mem_q [TABLE_DEPTH];
	value_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem_q[req.waddr] <= req.wdata;
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;
endmodule

[sv/hbf_search.sv]
module hbf_search (
	input  logic              clk,
	input  logic              arst_n,
	input  hbf_pkg::nb_t      num_bins,
	hbf_item_if.sink          items,
	hbf_result_if.source      results,
	output hbf_pkg::ram_req_t ram_req,
	input  hbf_pkg::value_t   rdata
);
	import hbf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_LO,
		S_RD_HI,
		S_CHK,
		S_SRCH,
		S_DONE
	} state_t;

	state_t   state_q;
	value_t   x_q;
	logic     last_q;
	nb_t      nb_q;
	logic     ge_lo_q;
	idx_t     lo_q, hi_q, mid_q;
	nb_t      k_q;
	logic     res_valid_q;
	nb_t      res_bin_q;
	logic     res_nob_q;
	logic     res_end_q;

	logic     accept;
	logic     x_ge;
	logic     x_eq;
	idx_t     mid0;
	idx_t     new_lo, new_hi, new_mid;
	logic [IDX_W:0] bound_sum;
	logic     more;
	logic     out_free;

	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && items.ready;

	assign x_ge = (x_q >= rdata);
	assign x_eq = (x_q == rdata);
	assign mid0 = IDX_W'(nb_q >> 1);

	// one halving step: narrow the bounds and pick the next probe at once
	always_comb begin
		new_lo    = x_ge ? mid_q : lo_q;
		new_hi    = x_ge ? hi_q : mid_q;
		bound_sum = {1'b0, new_lo} + {1'b0, new_hi};
		new_mid   = bound_sum[IDX_W:1];
		more      = ({1'b0, new_lo} + (IDX_W+1)'(1)) < {1'b0, new_hi};
	end

	always_comb begin
		ram_req.we    = accept && (items.op == OP_LOAD)
			&& (items.edge_index <= 7'(MAX_BINS));
		ram_req.waddr = IDX_W'(items.edge_index);
		ram_req.wdata = items.value;
		case (state_q)
			S_RD_LO: ram_req.raddr = '0;
			S_RD_HI: ram_req.raddr = IDX_W'(nb_q);
			S_CHK:   ram_req.raddr = mid0;
			S_SRCH:  ram_req.raddr = new_mid;
			default: ram_req.raddr = '0;
		endcase
	end

	assign out_free = !res_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			x_q         <= '0;
			last_q      <= 1'b0;
			nb_q        <= NB_W'(1);
			ge_lo_q     <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			k_q         <= '0;
			res_bin_q   <= '0;
			res_nob_q   <= 1'b0;
			res_end_q   <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				res_valid_q <= 1'b1;
			else if (results.valid && results.ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && items.op == OP_CLASSIFY) begin
						x_q     <= items.value;
						last_q  <= items.last_sample;
						nb_q    <= bins_in_use(num_bins);
						state_q <= S_RD_LO;
					end
				end
				S_RD_LO: state_q <= S_RD_HI;
				S_RD_HI: begin
					ge_lo_q <= x_ge;
					state_q <= S_CHK;
				end
				S_CHK: begin
					// rdata holds the top edge here
					if (x_eq) begin
						k_q     <= nb_q - NB_W'(1);
						state_q <= S_DONE;
					end else if (!(ge_lo_q && !x_ge)) begin
						k_q     <= nb_q;
						state_q <= S_DONE;
					end else if (nb_q > NB_W'(1)) begin
						lo_q    <= '0;
						hi_q    <= IDX_W'(nb_q);
						mid_q   <= mid0;
						state_q <= S_SRCH;
					end else begin
						k_q     <= '0;
						state_q <= S_DONE;
					end
				end
				S_SRCH: begin
					lo_q  <= new_lo;
					hi_q  <= new_hi;
					mid_q <= new_mid;
					if (!more) begin
						k_q     <= NB_W'(new_lo);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_bin_q   <= k_q;
						res_nob_q   <= (k_q == nb_q);
						res_end_q   <= last_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid     = res_valid_q;
	assign results.bin       = res_bin_q;
	assign results.no_bin    = res_nob_q;
	assign results.batch_end = res_end_q;
endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import hbf_pkg::*;

	localparam int STALL_LIMIT = 2000;  // cycles with work outstanding and no beat moving
	localparam int SETTLE      = 20;
	localparam int PER_PHASE   = 12;    // samples per bin setting

	typedef struct {
		logic       op;
		logic [6:0] edge_index;
		value_t     value;
		logic       last_sample;
	} item_t;

	typedef struct {
		logic [6:0] bin;
		logic       no_bin;
		logic       batch_end;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	nb_t  cfg_wdata = '0;

	hbf_item_if   items_if();
	hbf_result_if results_if();

	histogram_bin_finder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (items_if),
		.results  (results_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state, updated on accepted beats
	value_t edge_tbl [0:TABLE_DEPTH-1];
	int     bins_active = 1;
	bin_result_t expected_bins[$];

	// stimulus side: what has been queued so far
	item_t  pending_items[$];
	value_t planned_edge [0:TABLE_DEPTH-1];
	int     beats_queued = 0;
	int     beats_in = 0;
	int     samples_seen = 0;
	int     loads_seen = 0;
	int     results_seen = 0;
	int     fail_count = 0;
	int     mismatch_count = 0;
	int     stall_cycles = 0;
	int     src_idle_pct = 0;
	int     sink_stall_pct = 0;
	logic   in_taken = 1'b0;

	function automatic bin_result_t locate_bin(value_t x, logic last);
		bin_result_t r;
		int lo, hi, mid, k;
		value_t top;
		k = bins_active;
		top = edge_tbl[bins_active];
		if (x >= edge_tbl[0] && x < top) begin
			lo = 0;
			hi = bins_active;
			while (lo + 1 < hi) begin
				mid = (lo + hi) / 2;
				if (x >= edge_tbl[mid])
					lo = mid;
				else
					hi = mid;
			end
			k = lo;
		end
		// sample sitting exactly on the closing edge belongs to the last bin
		if (x == top)
			k = bins_active - 1;
		r.bin = 7'(k);
		r.no_bin = (k == bins_active);
		r.batch_end = last;
		return r;
	endfunction

	task automatic push_item(logic op, logic [6:0] idx, value_t v, logic last);
		item_t it;
		it.op = op;
		it.edge_index = idx;
		it.value = v;
		it.last_sample = last;
		if (op == OP_LOAD && idx < TABLE_DEPTH)
			planned_edge[idx] = v;
		pending_items.push_back(it);
		beats_queued++;
	endtask

	task automatic wait_idle();
		while (beats_queued != beats_in || expected_bins.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_bins(nb_t v);
		@(negedge clk);
		cfg_wdata = v;
		cfg_we = 1'b1;
		if (v == '0)
			bins_active = 1;
		else if (v > nb_t'(MAX_BINS))
			bins_active = MAX_BINS;
		else
			bins_active = int'(v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// style 0: full range, 1: narrow, 2: with repeated edges, 3: out of order
	task automatic queue_table(int nb, int style, bit keep_top);
		value_t vals [0:TABLE_DEPTH-1];
		value_t tv;
		int order [0:TABLE_DEPTH-1];
		int i, j, t, last_i;
		for (i = 0; i <= nb; i++) begin
			case (style)
				0: vals[i] = value_t'($urandom);
				1: vals[i] = value_t'($urandom_range(0, 40)) - 20;
				default: vals[i] = value_t'($urandom_range(0, 2000)) - 1000;
			endcase
		end
		if (style != 3) begin
			for (i = 1; i <= nb; i++) begin
				tv = vals[i];
				j = i - 1;
				while (j >= 0 && vals[j] > tv) begin
					vals[j+1] = vals[j];
					j--;
				end
				vals[j+1] = tv;
			end
		end
		if (style == 2)
			for (i = 1; i <= nb; i++)
				if ($urandom_range(0, 2) == 0)
					vals[i] = vals[i-1];
		last_i = keep_top ? nb - 1 : nb;
		for (i = 0; i <= last_i; i++)
			order[i] = i;
		for (i = last_i; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (i = 0; i <= last_i; i++)
			push_item(OP_LOAD, 7'(order[i]), vals[order[i]], 1'($urandom_range(0, 1)));
	endtask

	task automatic queue_samples(int nb, int n);
		value_t x, lo, hi;
		int s, r;
		logic last;
		for (s = 0; s < n; s++) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				push_item(OP_LOAD, 7'($urandom_range(TABLE_DEPTH, 127)), value_t'($urandom),
					1'($urandom_range(0, 1)));
			else if (r < 8)
				push_item(OP_LOAD, 7'($urandom_range(0, nb)), value_t'($urandom), 1'b0);
			lo = planned_edge[0];
			hi = planned_edge[nb];
			r = $urandom_range(0, 9);
			case (r)
				0, 1, 2: x = planned_edge[$urandom_range(0, nb)];
				3: x = planned_edge[$urandom_range(0, nb)] + 1;
				4: x = planned_edge[$urandom_range(0, nb)] - 1;
				5: x = $urandom_range(0, 1) ? value_t'(32'h7fff_ffff) : value_t'(32'h8000_0000);
				6, 7: x = value_t'($urandom);
				default: begin
					if (hi > lo)
						x = value_t'(longint'(lo) +
							longint'($urandom_range(0, 32'(longint'(hi) - longint'(lo)))));
					else
						x = lo;
				end
			endcase
			last = (s == n - 1) || ($urandom_range(0, 7) == 0);
			push_item(OP_CLASSIFY, 7'($urandom_range(0, 127)), x, last);
		end
	endtask

	// driver: new beat offered on the falling edge once the previous one has gone
	always @(negedge clk) begin
		item_t nxt;
		if (!arst_n) begin
			items_if.valid <= 1'b0;
		end else if (!items_if.valid || in_taken) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				nxt = pending_items.pop_front();
				items_if.op <= nxt.op;
				items_if.edge_index <= nxt.edge_index;
				items_if.value <= nxt.value;
				items_if.last_sample <= nxt.last_sample;
				items_if.valid <= 1'b1;
			end else begin
				items_if.valid <= 1'b0;
			end
		end
		results_if.ready <= arst_n && ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// monitor: predict on accepted items, check accepted results, watch for hangs
	always @(posedge clk) begin
		bin_result_t got, want;
		logic took_in, took_out;
		took_in = items_if.valid && items_if.ready;
		took_out = results_if.valid && results_if.ready;
		in_taken <= took_in;
		if (arst_n) begin
			if (took_in) begin
				beats_in++;
				if (items_if.op == OP_LOAD) begin
					loads_seen++;
					if (items_if.edge_index < TABLE_DEPTH)
						edge_tbl[items_if.edge_index] = items_if.value;
				end else begin
					samples_seen++;
					expected_bins.push_back(locate_bin(items_if.value, items_if.last_sample));
				end
			end
			if (took_out) begin
				results_seen++;
				got.bin = results_if.bin;
				got.no_bin = results_if.no_bin;
				got.batch_end = results_if.batch_end;
				if (expected_bins.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result beat with nothing expected: bin %0d no_bin %0b",
							$realtime, got.bin, got.no_bin);
				end else begin
					want = expected_bins.pop_front();
					if (got.bin !== want.bin || got.no_bin !== want.no_bin ||
						got.batch_end !== want.batch_end) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: bin %0d/%0d no_bin %0b/%0b batch_end %0b/%0b (exp/act)",
								$realtime, want.bin, got.bin, want.no_bin, got.no_bin,
								want.batch_end, got.batch_end);
					end
				end
			end
			if (took_in || took_out || (beats_queued == beats_in && expected_bins.size() == 0))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: %0d cycles without a beat, %0d results outstanding",
					stall_cycles, expected_bins.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int bins_plan [12] = '{64, 0, 127, 2, 7, 33, 5, 3, 1, 12, 16, 9};
		int idle_plan [4][2] = '{'{0, 0}, '{52, 0}, '{0, 52}, '{12, 12}};
		int p;
		items_if.valid = 1'b0;
		items_if.op = OP_LOAD;
		items_if.edge_index = '0;
		items_if.value = '0;
		items_if.last_sample = 1'b0;
		results_if.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, one bin in use after reset
		push_item(OP_LOAD, 7'd0, -100, 1'b0);
		push_item(OP_LOAD, 7'd1, 100, 1'b0);
		push_item(OP_CLASSIFY, 7'd0, -100, 1'b0);
		push_item(OP_CLASSIFY, 7'd0, 99, 1'b0);
		push_item(OP_CLASSIFY, 7'd0, 100, 1'b1);     // on closing edge
		push_item(OP_CLASSIFY, 7'd0, 101, 1'b0);
		push_item(OP_CLASSIFY, 7'd0, -101, 1'b0);
		push_item(OP_CLASSIFY, 7'd127, value_t'(32'h8000_0000), 1'b1);
		push_item(OP_LOAD, 7'd127, 7, 1'b1);         // beyond table, dropped
		push_item(OP_LOAD, 7'd65, 7, 1'b0);
		push_item(OP_LOAD, 7'd64, value_t'(32'h7fff_ffff), 1'b0);  // parked for later
		push_item(OP_LOAD, 7'd0, value_t'(32'h8000_0000), 1'b0);
		push_item(OP_LOAD, 7'd1, value_t'(32'h7fff_ffff), 1'b0);
		push_item(OP_CLASSIFY, 7'd0, value_t'(32'h8000_0000), 1'b0);
		push_item(OP_CLASSIFY, 7'd0, value_t'(32'h7fff_ffff), 1'b0);
		push_item(OP_CLASSIFY, 7'd0, 0, 1'b1);
		push_item(OP_LOAD, 7'd1, value_t'(32'h8000_0000), 1'b0);   // empty bin
		push_item(OP_CLASSIFY, 7'd0, value_t'(32'h8000_0000), 1'b0);
		push_item(OP_CLASSIFY, 7'd0, 5, 1'b0);
		push_item(OP_LOAD, 7'd0, 50, 1'b0);          // edges out of order
		push_item(OP_LOAD, 7'd1, -50, 1'b0);
		push_item(OP_CLASSIFY, 7'd0, 0, 1'b0);
		push_item(OP_CLASSIFY, 7'd0, 50, 1'b0);
		push_item(OP_CLASSIFY, 7'd0, -50, 1'b1);

		for (p = 0; p < 12; p++) begin
			wait_idle();
			write_bins(nb_t'(bins_plan[p]));
			src_idle_pct = idle_plan[p % 4][0];
			sink_stall_pct = idle_plan[p % 4][1];
			// first wide setting reuses the top edge loaded while one bin was in use
			queue_table(bins_active, p % 4, p == 0);
			queue_samples(bins_active, PER_PHASE);
		end

		wait_idle();
		if (expected_bins.size() != 0)
			fail_count++;
		$display("Covered %0d item beats: %0d edge loads, %0d samples, %0d results checked",
			beats_in, loads_seen, samples_seen, results_seen);
		$display("Bin settings exercised: 13 (zero, one, saturating and full table included); "
			, "%0d mismatches", mismatch_count);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
sv/hbf_pkg.sv
sv/hbf_item_if.sv
sv/hbf_result_if.sv
sv/hbf_edge_ram.sv
sv/hbf_search.sv
sv/histogram_bin_finder_core.sv
sim/testbench.sv
